### hw/rtl/nsr_pkg.sv
// Shared types and constants for the numeric string recognizer.
package nsr_pkg;

   localparam int CODE_W = 21;
   localparam int LEN_W  = 16;

   localparam longint unsigned MAX_LEN_DEF = 65535;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CODE_W-1:0] CH_NUL   = 21'd0;
   localparam logic [CODE_W-1:0] CH_TAB   = 21'd9;
   localparam logic [CODE_W-1:0] CH_CR    = 21'd13;
   localparam logic [CODE_W-1:0] CH_SPACE = 21'd32;
   localparam logic [CODE_W-1:0] CH_PCT   = 21'd37;
   localparam logic [CODE_W-1:0] CH_PLUS  = 21'd43;
   localparam logic [CODE_W-1:0] CH_MINUS = 21'd45;
   localparam logic [CODE_W-1:0] CH_DOT   = 21'd46;
   localparam logic [CODE_W-1:0] CH_ZERO  = 21'd48;
   localparam logic [CODE_W-1:0] CH_NINE  = 21'd57;
   localparam logic [CODE_W-1:0] CH_UA    = 21'd65;
   localparam logic [CODE_W-1:0] CH_UE    = 21'd69;
   localparam logic [CODE_W-1:0] CH_UF    = 21'd70;
   localparam logic [CODE_W-1:0] CH_UP    = 21'd80;
   localparam logic [CODE_W-1:0] CH_UX    = 21'd88;
   localparam logic [CODE_W-1:0] CH_LA    = 21'd97;
   localparam logic [CODE_W-1:0] CH_LE    = 21'd101;
   localparam logic [CODE_W-1:0] CH_LF    = 21'd102;
   localparam logic [CODE_W-1:0] CH_LP    = 21'd112;
   localparam logic [CODE_W-1:0] CH_LX    = 21'd120;

   typedef struct packed {
      logic is_end;
      logic is_space;
      logic is_sign;
      logic is_digit;
      logic is_zero;
      logic is_hex;
      logic is_dot;
      logic is_x;
      logic is_e;
      logic is_p;
      logic is_pct;
   } char_class_type;

   typedef enum logic [13:0] {
      ST_LEAD   = 14'b00000000000001,
      ST_SIGN   = 14'b00000000000010,
      ST_FIRST0 = 14'b00000000000100,
      ST_DINT   = 14'b00000000001000,
      ST_DFRAC  = 14'b00000000010000,
      ST_ESIGN  = 14'b00000000100000,
      ST_EFIRST = 14'b00000001000000,
      ST_EDIG   = 14'b00000010000000,
      ST_HINT   = 14'b00000100000000,
      ST_HFRAC  = 14'b00001000000000,
      ST_HSIGN  = 14'b00010000000000,
      ST_HDEC   = 14'b00100000000000,
      ST_DONE   = 14'b01000000000000,
      ST_FAIL   = 14'b10000000000000
   } scan_state_type;

   typedef struct packed {
      scan_state_type state;
      logic           result_load;
      logic           count_zero;
   } back_status_type;

endpackage

### hw/rtl/nsr_chan_if.sv
// Valid/ready channel interfaces for character beats and result beats.
interface nsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [nsr_pkg::CODE_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface nsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        number_found;
   logic                        whole_numeric;
   logic [nsr_pkg::LEN_W-1:0]   numeric_length;
   logic                        ends_in_percent;

   modport source (output valid, output number_found, output whole_numeric,
                   output numeric_length, output ends_in_percent, input ready);
   modport sink   (input valid, input number_found, input whole_numeric,
                   input numeric_length, input ends_in_percent, output ready);
endinterface

### hw/rtl/nsr_front.sv
// Front end: accepts character beats and registers their character class.
module nsr_front (
   input  logic                    clock,
   input  logic                    reset,
   nsr_req_if.sink                 req_chan,
   output logic                    cls_valid,
   input  logic                    cls_ready,
   output nsr_pkg::char_class_type cls_data
);

   logic                    valid_ff;
   logic                    valid_in;
   nsr_pkg::char_class_type cls_ff;
   nsr_pkg::char_class_type cls_in;
   logic                    accept;
   logic [nsr_pkg::CODE_W-1:0] c;

   assign req_chan.ready = !valid_ff || cls_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.char_code;

   always_comb begin
      cls_in.is_end   = (c == nsr_pkg::CH_NUL);
      cls_in.is_space = (c == nsr_pkg::CH_SPACE) ||
                        (c >= nsr_pkg::CH_TAB && c <= nsr_pkg::CH_CR);
      cls_in.is_sign  = (c == nsr_pkg::CH_PLUS) || (c == nsr_pkg::CH_MINUS);
      cls_in.is_digit = (c >= nsr_pkg::CH_ZERO) && (c <= nsr_pkg::CH_NINE);
      cls_in.is_zero  = (c == nsr_pkg::CH_ZERO);
      cls_in.is_hex   = cls_in.is_digit ||
                        (c >= nsr_pkg::CH_UA && c <= nsr_pkg::CH_UF) ||
                        (c >= nsr_pkg::CH_LA && c <= nsr_pkg::CH_LF);
      cls_in.is_dot   = (c == nsr_pkg::CH_DOT);
      cls_in.is_x     = (c == nsr_pkg::CH_UX) || (c == nsr_pkg::CH_LX);
      cls_in.is_e     = (c == nsr_pkg::CH_UE) || (c == nsr_pkg::CH_LE);
      cls_in.is_p     = (c == nsr_pkg::CH_UP) || (c == nsr_pkg::CH_LP);
      cls_in.is_pct   = (c == nsr_pkg::CH_PCT);
   end

   assign valid_in = accept || (valid_ff && !cls_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cls_ff <= cls_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_data  = cls_ff;

endmodule

### hw/rtl/nsr_queue.sv
// Small FIFO of classified characters between front and back.
module nsr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  nsr_pkg::char_class_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output nsr_pkg::char_class_type pop_data,
   output logic [nsr_pkg::QPTR_W:0] level
);

   localparam int PW = nsr_pkg::QPTR_W;

   nsr_pkg::char_class_type mem_ff [nsr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   level_ff, level_in;
   logic          push;
   logic          pop;

   assign push_ready = (level_ff != (PW+1)'(nsr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign level    = level_ff;

endmodule

### hw/rtl/nsr_back.sv
// Back end: scanner state machine, counters and the result register.
module nsr_back #(
   parameter longint unsigned MAX_LEN = nsr_pkg::MAX_LEN_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  nsr_pkg::char_class_type  pop_data,
   nsr_rsp_if.source                rsp_chan,
   output nsr_pkg::back_status_type status
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int LW    = nsr_pkg::LEN_W;

   typedef struct packed {
      nsr_pkg::scan_state_type state;
      logic                    take;
      logic                    pct;
   } step_type;

   nsr_pkg::scan_state_type state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        count_inc;
   logic [CNT_W-1:0]        number_end_ff, number_end_in;
   logic                    pct_ff, pct_in;
   logic                    junk_ff, junk_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic                    whole_ff, whole_in;
   logic [LW-1:0]           length_ff, length_in;
   logic                    rsp_pct_ff, rsp_pct_in;
   step_type                step;
   logic                    go;
   logic                    done_end;
   logic                    junk_set;

   function automatic step_type mk(nsr_pkg::scan_state_type s, logic t, logic p);
      step_type r;
      r.state = s;
      r.take  = t;
      r.pct   = p;
      return r;
   endfunction

   // Epsilon tails of the scanner: phases entered and left within one beat.
   function automatic step_type f_sign(nsr_pkg::char_class_type k);
      if (k.is_digit) return mk(k.is_zero ? nsr_pkg::ST_FIRST0 : nsr_pkg::ST_DINT, 1'b1, 1'b0);
      return mk(nsr_pkg::ST_FAIL, 1'b0, 1'b0);
   endfunction

   function automatic step_type f_pct(nsr_pkg::char_class_type k);
      if (k.is_pct) return mk(nsr_pkg::ST_DONE, 1'b1, 1'b1);
      return mk(nsr_pkg::ST_DONE, 1'b0, 1'b0);
   endfunction

   function automatic step_type f_dexp(nsr_pkg::char_class_type k);
      if (k.is_e) return mk(nsr_pkg::ST_ESIGN, 1'b1, 1'b0);
      return f_pct(k);
   endfunction

   function automatic step_type f_dint(nsr_pkg::char_class_type k);
      if (k.is_digit) return mk(nsr_pkg::ST_DINT, 1'b1, 1'b0);
      if (k.is_dot) return mk(nsr_pkg::ST_DFRAC, 1'b1, 1'b0);
      return f_dexp(k);
   endfunction

   function automatic step_type f_efirst(nsr_pkg::char_class_type k);
      if (k.is_digit) return mk(nsr_pkg::ST_EDIG, 1'b1, 1'b0);
      return mk(nsr_pkg::ST_FAIL, 1'b0, 1'b0);
   endfunction

   function automatic step_type f_hdec(nsr_pkg::char_class_type k);
      if (k.is_digit) return mk(nsr_pkg::ST_HDEC, 1'b1, 1'b0);
      return mk(nsr_pkg::ST_DONE, 1'b0, 1'b0);
   endfunction

   function automatic step_type f_hsign(nsr_pkg::char_class_type k);
      if (k.is_sign) return mk(nsr_pkg::ST_HDEC, 1'b1, 1'b0);
      return f_hdec(k);
   endfunction

   function automatic step_type f_hpexp(nsr_pkg::char_class_type k);
      if (k.is_p) return mk(nsr_pkg::ST_HSIGN, 1'b1, 1'b0);
      return f_hsign(k);
   endfunction

   always_comb begin
      case (state_ff)
         nsr_pkg::ST_LEAD: begin
            if (pop_data.is_space)     step = mk(nsr_pkg::ST_LEAD, 1'b1, 1'b0);
            else if (pop_data.is_sign) step = mk(nsr_pkg::ST_SIGN, 1'b1, 1'b0);
            else                       step = f_sign(pop_data);
         end
         nsr_pkg::ST_SIGN:   step = f_sign(pop_data);
         nsr_pkg::ST_FIRST0: begin
            if (pop_data.is_x) step = mk(nsr_pkg::ST_HINT, 1'b1, 1'b0);
            else               step = f_dint(pop_data);
         end
         nsr_pkg::ST_DINT:   step = f_dint(pop_data);
         nsr_pkg::ST_DFRAC: begin
            if (pop_data.is_digit) step = mk(nsr_pkg::ST_DFRAC, 1'b1, 1'b0);
            else                   step = f_dexp(pop_data);
         end
         nsr_pkg::ST_ESIGN: begin
            if (pop_data.is_sign) step = mk(nsr_pkg::ST_EFIRST, 1'b1, 1'b0);
            else                  step = f_efirst(pop_data);
         end
         nsr_pkg::ST_EFIRST: step = f_efirst(pop_data);
         nsr_pkg::ST_EDIG: begin
            if (pop_data.is_digit) step = mk(nsr_pkg::ST_EDIG, 1'b1, 1'b0);
            else                   step = f_pct(pop_data);
         end
         nsr_pkg::ST_HINT: begin
            if (pop_data.is_hex)      step = mk(nsr_pkg::ST_HINT, 1'b1, 1'b0);
            else if (pop_data.is_dot) step = mk(nsr_pkg::ST_HFRAC, 1'b1, 1'b0);
            else                      step = f_hpexp(pop_data);
         end
         nsr_pkg::ST_HFRAC: begin
            if (pop_data.is_hex) step = mk(nsr_pkg::ST_HFRAC, 1'b1, 1'b0);
            else                 step = f_hpexp(pop_data);
         end
         nsr_pkg::ST_HSIGN:  step = f_hsign(pop_data);
         nsr_pkg::ST_HDEC:   step = f_hdec(pop_data);
         nsr_pkg::ST_DONE:   step = mk(nsr_pkg::ST_DONE, 1'b0, 1'b0);
         default:            step = mk(nsr_pkg::ST_FAIL, 1'b0, 1'b0);
      endcase
   end

   // A NUL beat waits while an earlier result is still pending.
   assign pop_ready = !pop_data.is_end || !rsp_valid_ff || rsp_chan.ready;
   assign go        = pop_valid && pop_ready;
   assign done_end  = go && pop_data.is_end;

   assign count_inc = (count_ff == CNT_W'(MAX_LEN)) ? count_ff : count_ff + 1'b1;
   assign junk_set  = (step.state == nsr_pkg::ST_DONE) && !step.take &&
                      !pop_data.is_end && !pop_data.is_space;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      number_end_in = number_end_ff;
      pct_in        = pct_ff;
      junk_in       = junk_ff;
      if (done_end) begin
         state_in      = nsr_pkg::ST_LEAD;
         count_in      = '0;
         number_end_in = '0;
         pct_in        = 1'b0;
         junk_in       = 1'b0;
      end else if (go) begin
         state_in      = step.state;
         count_in      = count_inc;
         number_end_in = step.take ? count_inc : number_end_ff;
         pct_in        = pct_ff | step.pct;
         junk_in       = junk_ff | junk_set;
      end
   end

   assign found_in     = (step.state == nsr_pkg::ST_DONE);
   assign whole_in     = found_in && !junk_ff;
   assign length_in    = found_in ? LW'(number_end_ff) : '0;
   assign rsp_pct_in   = found_in && pct_ff;
   assign rsp_valid_in = done_end || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nsr_pkg::ST_LEAD;
         count_ff      <= '0;
         number_end_ff <= '0;
         pct_ff        <= 1'b0;
         junk_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         number_end_ff <= number_end_in;
         pct_ff        <= pct_in;
         junk_ff       <= junk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (done_end) begin
         found_ff   <= found_in;
         whole_ff   <= whole_in;
         length_ff  <= length_in;
         rsp_pct_ff <= rsp_pct_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.number_found    = found_ff;
   assign rsp_chan.whole_numeric   = whole_ff;
   assign rsp_chan.numeric_length  = length_ff;
   assign rsp_chan.ends_in_percent = rsp_pct_ff;

   assign status.state       = state_ff;
   assign status.result_load = done_end;
   assign status.count_zero  = (count_ff == '0) && (number_end_ff == '0);

endmodule

### hw/rtl/numeric_string_recognizer.sv
// Numeric string recognizer top level: front, queue, back and checks.
// Takes one character beat per clock on req_chan while the queue has room; a NUL (code 0)
// closes the string and presents one result beat on rsp_chan by way of the front class
// register, the queue and the back result register. Throughput is set by the back-end
// scanner, which resolves one character per cycle including the phases it passes through
// within a beat, but holds a NUL while an earlier result is still pending on rsp_chan.
// Lengths count from the string start, leading whitespace included, and stop at MAX_LEN;
// numeric_length carries the low 16 bits. A four-beat queue lets the front keep taking
// characters while a result waits on rsp_chan.
module numeric_string_recognizer #(
   parameter longint unsigned MAX_LEN = nsr_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   nsr_req_if.sink   req_chan,
   nsr_rsp_if.source rsp_chan
);

   logic                     cls_valid;
   logic                     cls_ready;
   nsr_pkg::char_class_type  cls_data;
   logic                     pop_valid;
   logic                     pop_ready;
   nsr_pkg::char_class_type  pop_data;
   logic [nsr_pkg::QPTR_W:0] q_level;
   nsr_pkg::back_status_type back_status;

   nsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cls_valid (cls_valid),
      .cls_ready (cls_ready),
      .cls_data  (cls_data)
   );

   nsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cls_valid),
      .push_ready (cls_ready),
      .push_data  (cls_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .level      (q_level)
   );

   nsr_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan),
      .status    (back_status)
   );

   // No number means every other result field is clear.
   a_no_number_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.number_found |->
         !rsp_chan.whole_numeric && (rsp_chan.numeric_length == '0) &&
         !rsp_chan.ends_in_percent)
      else $error("result fields set without a number");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= (nsr_pkg::QPTR_W+1)'(nsr_pkg::QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // After a NUL the scanner starts the next string from scratch.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      back_status.result_load |=>
         (back_status.state == nsr_pkg::ST_LEAD) && back_status.count_zero)
      else $error("scanner not restarted after end of string");

endmodule
